FILE: rtl/odometry_path_recorder_assert.svh
// Assertion macros used by the checker file opr_checker.
`ifndef ODOMETRY_PATH_RECORDER_ASSERT_SVH
`define ODOMETRY_PATH_RECORDER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define OPR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("opr assertion failed");
// Implication checked in the cycle after the antecedent.
`define OPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("opr assertion failed");
`endif

FILE: rtl/opr_pkg.sv
//------------------------------------------------------------------------------
// opr_pkg
// Types, constants and state codes shared by the path recorder modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
package opr_pkg;
  localparam int POSE_DEPTH  = 1024;
  localparam int STACK_DEPTH = 16;
  localparam int PAW = $clog2(POSE_DEPTH);
  localparam int PCW = PAW + 1;
  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int SCW = SAW + 1;

  localparam logic [2:0] REQ_SAMPLE = 3'd0;
  localparam logic [2:0] REQ_PUSH   = 3'd1;
  localparam logic [2:0] REQ_POP    = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_START  = 3'd4;

  localparam logic [1:0] MODE_RECORD = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;

  localparam logic [2:0] CFG_MODE  = 3'd0;
  localparam logic [2:0] CFG_RDIST = 3'd1;
  localparam logic [2:0] CFG_RANG  = 3'd2;
  localparam logic [2:0] CFG_CDIST = 3'd3;
  localparam logic [2:0] CFG_CANG  = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [15:0]        yaw;
    logic [4:0]         pop_count;
    logic               keep_previous;
  } in_item_t;

  typedef struct packed {
    logic        recorded;
    logic [10:0] removed_count;
    logic        clearing_error;
    logic        store_full;
    logic [10:0] path_length;
    logic [4:0]  stacked_count;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_READ, ST_WAIT, ST_SQUARE, ST_SUM, ST_JUDGE,
    ST_POP, ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic read_last;
    logic square;
    logic sum;
    logic append;
    logic write_start;
    logic drop_last;
    logic push;
    logic pop_one;
    logic discard;
    logic set_full;
    logic set_cerr;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] req_type;
    logic [1:0] mode;
    logic       path_empty;
    logic       path_multi;
    logic       mem_full;
    logic       stack_full;
    logic       stack_empty;
    logic       pops_left;
    logic       keep;
    logic       start_ok;
    logic       rec_take;
    logic       clr_near;
    logic       clr_err;
  } status_t;
endpackage

FILE: rtl/opr_ctrl.sv
//------------------------------------------------------------------------------
// opr_ctrl
// Sequencer that steps each request through the datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module opr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output logic            done,
  input  opr_pkg::status_t st,
  output opr_pkg::cmd_t   cmd
);
  import opr_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    done = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (st.req_type == REQ_SAMPLE && st.mode == MODE_RECORD) begin
          if (st.path_empty) begin
            if (st.mem_full) cmd.set_full = 1'b1;
            else cmd.append = 1'b1;
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end else if (st.req_type == REQ_SAMPLE && st.mode == MODE_CLEAR) begin
          state_nxt = st.path_multi ? ST_READ : ST_DONE;
        end else if (st.req_type == REQ_PUSH) begin
          if (st.stack_full) cmd.set_full = 1'b1;
          else cmd.push = 1'b1;
          state_nxt = ST_DONE;
        end else if (st.req_type == REQ_POP) begin
          if (!st.keep) cmd.discard = 1'b1;
          state_nxt = ST_POP;
        end else if (st.req_type == REQ_CLEAR) begin
          cmd.discard = 1'b1;
          state_nxt = ST_DONE;
        end else if (st.req_type == REQ_START) begin
          if (st.start_ok) cmd.write_start = 1'b1;
          else if (st.mem_full) cmd.set_full = 1'b1;
          else cmd.append = 1'b1;
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_READ: begin
        cmd.read_last = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        state_nxt = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        if (st.mode == MODE_RECORD) begin
          if (st.rec_take) begin
            if (st.mem_full) cmd.set_full = 1'b1;
            else cmd.append = 1'b1;
          end
          state_nxt = ST_DONE;
        end else if (st.clr_near) begin
          cmd.drop_last = 1'b1;
          state_nxt = ST_DECIDE;
        end else begin
          cmd.set_cerr = st.clr_err;
          state_nxt = ST_DONE;
        end
      end
      ST_POP: begin
        if (st.pops_left && !st.stack_empty) cmd.pop_one = 1'b1;
        else state_nxt = ST_DONE;
      end
      ST_DONE: begin
        done = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: rtl/opr_datapath.sv
//------------------------------------------------------------------------------
// opr_datapath
// Pose memory, segment stack, pointers, configuration and distance arithmetic.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module opr_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [18:0]       cfg_data,
  input  opr_pkg::in_item_t in_item,
  input  opr_pkg::cmd_t     cmd,
  output opr_pkg::status_t  st,
  output opr_pkg::out_item_t result
);
  import opr_pkg::*;

  logic [1:0]  mode_r;
  logic [18:0] rdist_r, cdist_r;
  logic [15:0] rang_r, cang_r;

  in_item_t    item_r;
  logic [PCW-1:0] wp_r, cs_r;
  logic [SCW-1:0] lvl_r;
  logic [4:0]     pops_r;
  logic           recorded_r, cerr_r, full_r;
  logic [10:0]    removed_r;

  logic [31:0] mem_x [POSE_DEPTH];
  logic [31:0] mem_y [POSE_DEPTH];
  logic [15:0] mem_yaw [POSE_DEPTH];
  logic [PCW-1:0] stack_mem [STACK_DEPTH];

  logic [31:0] rd_x_r, rd_y_r;
  logic [15:0] rd_yaw_r;
  logic [39:0] sqx_r, sqy_r;
  logic [40:0] d2_r;
  logic        far_r, far2_r;
  logic [15:0] ydiff_r;
  logic [37:0] tsq_r;

  logic [32:0] dx, dy, ax, ay;
  logic [15:0] yd, yabs;
  logic [18:0] dthr;
  logic        wr_en;
  logic [PAW-1:0] wr_addr;
  logic [PAW-1:0] last_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_RECORD;
      rdist_r <= 19'd328;
      rang_r  <= 16'd1043;
      cdist_r <= 19'd3277;
      cang_r  <= 16'd1043;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_data[1:0];
        CFG_RDIST: rdist_r <= cfg_data;
        CFG_RANG:  rang_r  <= cfg_data[15:0];
        CFG_CDIST: cdist_r <= cfg_data;
        CFG_CANG:  cang_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign last_addr = PAW'(wp_r - PCW'(1));
  assign wr_en     = cmd.append | cmd.write_start;
  assign wr_addr   = cmd.write_start ? cs_r[PAW-1:0] : wp_r[PAW-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_x[wr_addr]   <= item_r.pos_x;
      mem_y[wr_addr]   <= item_r.pos_y;
      mem_yaw[wr_addr] <= item_r.yaw;
    end
    if (cmd.read_last) begin
      rd_x_r   <= mem_x[last_addr];
      rd_y_r   <= mem_y[last_addr];
      rd_yaw_r <= mem_yaw[last_addr];
    end
    if (cmd.push) begin
      stack_mem[lvl_r[SAW-1:0]] <= cs_r;
    end
  end

  // Differences and magnitudes of the stored pose against the request.
  assign dx = {item_r.pos_x[31], item_r.pos_x} - {rd_x_r[31], rd_x_r};
  assign dy = {item_r.pos_y[31], item_r.pos_y} - {rd_y_r[31], rd_y_r};
  assign ax = dx[32] ? -dx : dx;
  assign ay = dy[32] ? -dy : dy;
  assign yd = item_r.yaw - rd_yaw_r;
  assign yabs = yd[15] ? 16'(17'h10000 - {1'b0, yd}) : yd;
  assign dthr = (mode_r == MODE_RECORD) ? rdist_r : cdist_r;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      far_r   <= (ax[32:20] != '0) || (ay[32:20] != '0);
      sqx_r   <= ax[19:0] * ax[19:0];
      sqy_r   <= ay[19:0] * ay[19:0];
      ydiff_r <= yabs;
      tsq_r   <= dthr * dthr;
    end
    if (cmd.sum) begin
      d2_r   <= {1'b0, sqx_r} + {1'b0, sqy_r};
      far2_r <= far_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r       <= '0;
      cs_r       <= '0;
      lvl_r      <= '0;
      pops_r     <= '0;
      recorded_r <= 1'b0;
      cerr_r     <= 1'b0;
      full_r     <= 1'b0;
      removed_r  <= '0;
    end else begin
      if (cmd.load) begin
        pops_r     <= in_item.pop_count;
        recorded_r <= 1'b0;
        cerr_r     <= 1'b0;
        full_r     <= 1'b0;
        removed_r  <= '0;
      end
      if (cmd.append) begin
        wp_r       <= wp_r + PCW'(1);
        recorded_r <= 1'b1;
      end
      if (cmd.write_start) recorded_r <= 1'b1;
      if (cmd.set_full) full_r <= 1'b1;
      if (cmd.set_cerr) cerr_r <= 1'b1;
      if (cmd.drop_last) begin
        wp_r      <= wp_r - PCW'(1);
        removed_r <= removed_r + 11'd1;
      end
      if (cmd.discard) wp_r <= cs_r;
      if (cmd.push) begin
        lvl_r <= lvl_r + SCW'(1);
        cs_r  <= wp_r;
      end
      if (cmd.pop_one) begin
        lvl_r  <= lvl_r - SCW'(1);
        cs_r   <= stack_mem[SAW'(lvl_r - SCW'(1))];
        pops_r <= pops_r - 5'd1;
      end
    end
  end

  always_comb begin
    st.req_type    = item_r.req_type;
    st.mode        = mode_r;
    st.path_empty  = (wp_r == cs_r);
    st.path_multi  = (wp_r - cs_r) > PCW'(1);
    st.mem_full    = (wp_r == PCW'(POSE_DEPTH));
    st.stack_full  = (lvl_r == SCW'(STACK_DEPTH));
    st.stack_empty = (lvl_r == '0);
    st.pops_left   = (pops_r != '0);
    st.keep        = item_r.keep_previous;
    st.start_ok    = (wp_r > cs_r) && (cs_r < PCW'(POSE_DEPTH));
    st.rec_take    = far2_r || ({3'b0, d2_r} > {6'b0, tsq_r})
                     || (ydiff_r > rang_r);
    st.clr_near    = !far2_r && ({3'b0, d2_r} < {6'b0, tsq_r})
                     && (ydiff_r < cang_r);
    st.clr_err     = far2_r || ({3'b0, d2_r} > {4'b0, tsq_r, 2'b00});
  end

  assign result.recorded       = recorded_r;
  assign result.removed_count  = removed_r;
  assign result.clearing_error = cerr_r;
  assign result.store_full     = full_r;
  assign result.path_length    = 11'(wp_r - cs_r);
  assign result.stacked_count  = 5'(lvl_r);
endmodule

FILE: rtl/odometry_path_recorder.sv
// A command goes from DECIDE straight to DONE; a pop passes through POP once per
// popped segment; a sample compared against the last pose steps through READ,
// WAIT, SQUARE, SUM and JUDGE, and each pose removed by a clear-mode sample repeats them.
// One request at a time; busy stays high through the out_valid cycle and the
// next request can be accepted in the cycle after it.
// Synchronous active-low reset empties path and stack; the receiver cannot stall.
//------------------------------------------------------------------------------
// odometry_path_recorder
// Records odometry poses into stacked path segments.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
module odometry_path_recorder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  opr_pkg::in_item_t  in_item,
  output logic               out_valid,
  output opr_pkg::out_item_t out_item,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [18:0]        cfg_data
);
  import opr_pkg::*;

  cmd_t    cmd;
  status_t st;

  opr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .done(out_valid), .st(st), .cmd(cmd)
  );

  opr_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_item(in_item), .cmd(cmd), .st(st),
    .result(out_item)
  );
endmodule

FILE: rtl/opr_checker.sv
//------------------------------------------------------------------------------
// opr_checker
// Port-level checks on the path recorder.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "odometry_path_recorder_assert.svh"
module opr_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input opr_pkg::out_item_t out_item
);
  import opr_pkg::*;

  `OPR_ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
  `OPR_ASSERT_IMPL(a_valid_busy, clk, rst_n, out_valid, busy)
  `OPR_ASSERT_NEXT(a_valid_ends, clk, rst_n, out_valid, !busy && !out_valid)
  `OPR_ASSERT_IMPL(a_one_flag, clk, rst_n, out_valid,
                   !(out_item.recorded && out_item.store_full))
endmodule

bind odometry_path_recorder opr_checker u_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);
